@@ design/cpg_pkg.sv @@
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared widths, command and register codes, reset values and the control
// record that travels between the scan and evaluation stages.
// ----------------------------------------------------------------------------
package cpg_pkg;

	localparam int RADIUS_W   = 10;
	localparam int SCAN_W     = RADIUS_W + 1;
	localparam int DIST_W     = SCAN_W + 1;
	localparam int SQ_W       = 2 * RADIUS_W;
	localparam int DSUM_W     = SQ_W + 1;
	localparam int ADDR_W     = 30;
	localparam int PITCH_W    = 15;
	localparam int SCREEN_W   = 11;
	localparam int COLOR_W    = 32;
	localparam int ROW_W      = SCREEN_W + PITCH_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 30;

	// Width of the ring drawn when the fill flag is clear.
	localparam int RING_W = 2;

	localparam logic [ADDR_W-1:0]   FRAME_BASE_RST    = 30'd0;
	localparam logic [PITCH_W-1:0]  LINE_PITCH_RST    = 15'd3200;
	localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 11'd800;
	localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 11'd600;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_BASE    = 2'd0,
		REG_LINE_PITCH    = 2'd1,
		REG_SCREEN_WIDTH  = 2'd2,
		REG_SCREEN_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic active;
		logic done;
	} cpg_ctl_t;

endpackage

@@ design/cpg_if.sv @@
// ----------------------------------------------------------------------------
// cpg_if
// Valid/ready channels for circle commands and for pixel write results.
// ----------------------------------------------------------------------------
interface cpg_cmd_if #(
	parameter int COORD_BITS = 12
);
	import cpg_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         command;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic [RADIUS_W-1:0]          radius;
	logic [COLOR_W-1:0]           color;
	logic                         fill;

	modport source (output valid, command, center_x, center_y, radius, color, fill,
		input ready);
	modport sink (input valid, command, center_x, center_y, radius, color, fill,
		output ready);
endinterface

interface cpg_pix_if;
	import cpg_pkg::*;

	logic                valid;
	logic                ready;
	logic                write_enable;
	logic [ADDR_W-1:0]   pixel_address;
	logic [COLOR_W-1:0]  pixel_color;
	logic                done_res;

	modport source (output valid, write_enable, pixel_address, pixel_color, done_res,
		input ready);
	modport sink (input valid, write_enable, pixel_address, pixel_color, done_res,
		output ready);
endinterface

@@ design/cpg_scan.sv @@
// ----------------------------------------------------------------------------
// cpg_scan
// Holds the circle operands and the bounding-box scan position, and registers
// the offsets of the current position into the first pipeline stage.
// ----------------------------------------------------------------------------
module cpg_scan #(
	parameter int COORD_BITS = 12,
	parameter int PIXEL_BITS = 32,
	parameter int PW = ((COORD_BITS > cpg_pkg::SCAN_W) ? COORD_BITS : cpg_pkg::SCAN_W) + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic                              load_s1,
	input  logic                              command,
	input  logic signed [COORD_BITS-1:0]      center_x,
	input  logic signed [COORD_BITS-1:0]      center_y,
	input  logic [cpg_pkg::RADIUS_W-1:0]      radius,
	input  logic [cpg_pkg::COLOR_W-1:0]       color,
	input  logic                              fill,
	output logic                              valid_s1,
	output cpg_pkg::cpg_ctl_t                 ctl_s1,
	output logic signed [cpg_pkg::DIST_W-1:0] dx_s1,
	output logic signed [cpg_pkg::DIST_W-1:0] dy_s1,
	output logic signed [PW-1:0]              px_s1,
	output logic signed [PW-1:0]              py_s1,
	output logic [cpg_pkg::RADIUS_W-1:0]      radius_s1,
	output logic                              fill_s1,
	output logic [PIXEL_BITS-1:0]             color_s1
);
	import cpg_pkg::*;

	logic [SCAN_W-1:0]            scan_x_q;
	logic [SCAN_W-1:0]            scan_y_q;
	logic signed [COORD_BITS-1:0] held_cx_q;
	logic signed [COORD_BITS-1:0] held_cy_q;
	logic [RADIUS_W-1:0]          held_r_q;
	logic [PIXEL_BITS-1:0]        held_color_q;
	logic                         held_fill_q;
	logic                         busy_q;

	logic [SCAN_W-1:0]      last;
	logic signed [DIST_W-1:0] dx;
	logic signed [DIST_W-1:0] dy;
	logic signed [PW-1:0]   px;
	logic signed [PW-1:0]   py;
	logic                   end_x;
	logic                   end_xy;
	logic                   is_start;

	always_comb begin
		last     = {held_r_q, 1'b0};
		dx       = $signed({1'b0, scan_x_q}) - $signed({2'b00, held_r_q});
		dy       = $signed({1'b0, scan_y_q}) - $signed({2'b00, held_r_q});
		px       = PW'(held_cx_q) + PW'(dx);
		py       = PW'(held_cy_q) + PW'(dy);
		end_x    = scan_x_q >= last;
		end_xy   = end_x && (scan_y_q >= last);
		is_start = command == CMD_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_x_q     <= '0;
			scan_y_q     <= '0;
			held_cx_q    <= '0;
			held_cy_q    <= '0;
			held_r_q     <= '0;
			held_color_q <= '0;
			held_fill_q  <= 1'b0;
			busy_q       <= 1'b0;
		end else if (take) begin
			if (is_start) begin
				held_cx_q    <= center_x;
				held_cy_q    <= center_y;
				held_r_q     <= radius;
				held_color_q <= color[PIXEL_BITS-1:0];
				held_fill_q  <= fill;
				scan_x_q     <= '0;
				scan_y_q     <= '0;
				busy_q       <= 1'b1;
			end else if (busy_q) begin
				if (end_x) begin
					scan_x_q <= '0;
					if (end_xy) begin
						scan_y_q <= '0;
						busy_q   <= 1'b0;
					end else begin
						scan_y_q <= scan_y_q + 1'b1;
					end
				end else begin
					scan_x_q <= scan_x_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && take) begin
			ctl_s1.active <= !is_start && busy_q;
			ctl_s1.done   <= !is_start && (!busy_q || end_xy);
			dx_s1         <= dx;
			dy_s1         <= dy;
			px_s1         <= px;
			py_s1         <= py;
			radius_s1     <= held_r_q;
			fill_s1       <= held_fill_q;
			color_s1      <= held_color_q;
		end
	end

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_start |=> busy_q && scan_x_q == '0 && scan_y_q == '0)
		else $error("start did not arm the scan at the top left corner");

	a_scan_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> scan_x_q <= last && scan_y_q <= last)
		else $error("scan position left the bounding box");

endmodule

@@ design/cpg_eval.sv @@
// ----------------------------------------------------------------------------
// cpg_eval
// Squares, row offset and visibility in the second stage; distance test,
// address sum and the result register in the third stage.
// ----------------------------------------------------------------------------
module cpg_eval #(
	parameter int COORD_BITS = 12,
	parameter int PIXEL_BITS = 32,
	parameter int PW = ((COORD_BITS > cpg_pkg::SCAN_W) ? COORD_BITS : cpg_pkg::SCAN_W) + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [cpg_pkg::ADDR_W-1:0]        frame_base,
	input  logic [cpg_pkg::PITCH_W-1:0]       line_pitch,
	input  logic [cpg_pkg::SCREEN_W-1:0]      screen_width,
	input  logic [cpg_pkg::SCREEN_W-1:0]      screen_height,
	input  logic                              valid_s1,
	input  cpg_pkg::cpg_ctl_t                 ctl_s1,
	input  logic signed [cpg_pkg::DIST_W-1:0] dx_s1,
	input  logic signed [cpg_pkg::DIST_W-1:0] dy_s1,
	input  logic signed [PW-1:0]              px_s1,
	input  logic signed [PW-1:0]              py_s1,
	input  logic [cpg_pkg::RADIUS_W-1:0]      radius_s1,
	input  logic                              fill_s1,
	input  logic [PIXEL_BITS-1:0]             color_s1,
	output logic                              ready_s1,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              write_enable,
	output logic [cpg_pkg::ADDR_W-1:0]        pixel_address,
	output logic [cpg_pkg::COLOR_W-1:0]       pixel_color,
	output logic                              done_res
);
	import cpg_pkg::*;

	localparam int PIXEL_BYTES = PIXEL_BITS / 8;
	localparam int PXB_W       = SCREEN_W + 3;

	logic ready_s2;
	logic ready_s3;

	// Second stage.
	logic                    valid_s2;
	cpg_ctl_t                ctl_s2;
	logic [SQ_W-1:0]         sqx_s2;
	logic [SQ_W-1:0]         sqy_s2;
	logic [SQ_W-1:0]         rsq_s2;
	logic [SQ_W-1:0]         inner_s2;
	logic [ROW_W-1:0]        row_s2;
	logic [SCREEN_W-1:0]     pxb_s2;
	logic                    vis_s2;
	logic                    fill_s2;
	logic [PIXEL_BITS-1:0]   color_s2;

	logic signed [2*DIST_W-1:0]       sqx_full;
	logic signed [2*DIST_W-1:0]       sqy_full;
	logic signed [RADIUS_W:0]         rm2;
	logic signed [2*RADIUS_W+1:0]     inner_full;
	logic [SQ_W-1:0]                  rsq;
	logic [ROW_W-1:0]                 row;
	logic                             vis;

	// Third stage.
	logic                  valid_s3;
	logic                  we_s3;
	logic [ADDR_W-1:0]     addr_s3;
	logic [COLOR_W-1:0]    color_s3;
	logic                  done_s3;

	logic [DSUM_W-1:0]     d2;
	logic                  hit;
	logic                  we;
	logic [PXB_W-1:0]      px_bytes;
	logic [ADDR_W-1:0]     addr;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	always_comb begin
		sqx_full   = dx_s1 * dx_s1;
		sqy_full   = dy_s1 * dy_s1;
		rsq        = radius_s1 * radius_s1;
		rm2        = $signed({1'b0, radius_s1}) - $signed((RADIUS_W + 1)'(RING_W));
		inner_full = rm2 * rm2;
		row        = ROW_W'(py_s1[SCREEN_W-1:0]) * ROW_W'(line_pitch);
		vis        = !px_s1[PW-1] && !py_s1[PW-1]
			&& (px_s1 < $signed(PW'(screen_width)))
			&& (py_s1 < $signed(PW'(screen_height)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			ctl_s2   <= ctl_s1;
			sqx_s2   <= sqx_full[SQ_W-1:0];
			sqy_s2   <= sqy_full[SQ_W-1:0];
			rsq_s2   <= rsq;
			inner_s2 <= inner_full[SQ_W-1:0];
			row_s2   <= row;
			pxb_s2   <= px_s1[SCREEN_W-1:0];
			vis_s2   <= vis;
			fill_s2  <= fill_s1;
			color_s2 <= color_s1;
		end
	end

	always_comb begin
		d2       = DSUM_W'(sqx_s2) + DSUM_W'(sqy_s2);
		hit      = (d2 <= DSUM_W'(rsq_s2)) && (fill_s2 || d2 >= DSUM_W'(inner_s2));
		we       = ctl_s2.active && hit && vis_s2;
		px_bytes = PXB_W'(pxb_s2) * PXB_W'(PIXEL_BYTES);
		addr     = frame_base + ADDR_W'(row_s2) + ADDR_W'(px_bytes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			we_s3    <= we;
			addr_s3  <= we ? addr : '0;
			color_s3 <= we ? COLOR_W'(color_s2) : '0;
			done_s3  <= ctl_s2.done;
		end
	end

	assign out_valid     = valid_s3;
	assign write_enable  = we_s3;
	assign pixel_address = addr_s3;
	assign pixel_color   = color_s3;
	assign done_res      = done_s3;

endmodule

@@ design/circle_pixel_generator_core.sv @@
// ----------------------------------------------------------------------------
// circle_pixel_generator_core
// Path: an accepted command beat passes the scan, second and result registers.
// Throughput: one beat per cycle unless the pixel side stalls; one result per command.
// Reset: clears the scan and the pipeline, leaves the block idle, and sets the
// registers to base 0, pitch 3200, width 800 and height 600.
// ----------------------------------------------------------------------------
// Rasterizes one circle as a sequence of frame buffer pixel writes. A start
// command loads the center, radius, color and fill flag; each step command
// examines the next position of the square bounding box in row-major order.
//
// The datapath is three register stages. The scan stage updates the held
// operands and the scan position on every accepted beat and registers the
// offsets dx and dy of the position from the center, together with its screen
// coordinates. The second stage forms dx squared, dy squared, the outer and
// inner radius squares and the row offset y times the line pitch, each product
// in its own multiplier. The third stage compares the squared distance with
// both bounds, adds up the byte address and fills the result register.
//
// Each stage has its own valid bit and takes a new beat whenever it is empty
// or the stage behind it moves, so bubbles collapse and a waiting result
// does not hold back commands while earlier stages have room.
//
// Configuration registers are plain flops written through the cfg port; they
// are expected to change only while no command is in flight.
// ----------------------------------------------------------------------------
module circle_pixel_generator_core #(
	parameter int COORD_BITS = 12,
	parameter int PIXEL_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cpg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cpg_pkg::CFG_DATA_W-1:0]    cfg_data,
	cpg_cmd_if.sink                           cmd,
	cpg_pix_if.source                         pix
);
	import cpg_pkg::*;

	localparam int PW = ((COORD_BITS > SCAN_W) ? COORD_BITS : SCAN_W) + 1;

	// Configuration registers.
	logic [ADDR_W-1:0]   frame_base_q;
	logic [PITCH_W-1:0]  line_pitch_q;
	logic [SCREEN_W-1:0] screen_width_q;
	logic [SCREEN_W-1:0] screen_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q    <= FRAME_BASE_RST;
			line_pitch_q    <= LINE_PITCH_RST;
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_BASE:    frame_base_q    <= cfg_data[ADDR_W-1:0];
				REG_LINE_PITCH:    line_pitch_q    <= cfg_data[PITCH_W-1:0];
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[SCREEN_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[SCREEN_W-1:0];
			endcase
		end
	end

	// A beat enters when the first stage has room.
	logic                       take;
	logic                       ready_s1;
	logic                       valid_s1;
	cpg_ctl_t                   ctl_s1;
	logic signed [DIST_W-1:0]   dx_s1;
	logic signed [DIST_W-1:0]   dy_s1;
	logic signed [PW-1:0]       px_s1;
	logic signed [PW-1:0]       py_s1;
	logic [RADIUS_W-1:0]        radius_s1;
	logic                       fill_s1;
	logic [PIXEL_BITS-1:0]      color_s1;

	assign cmd.ready = ready_s1;
	assign take      = cmd.valid && ready_s1;

	cpg_scan #(
		.COORD_BITS (COORD_BITS),
		.PIXEL_BITS (PIXEL_BITS),
		.PW         (PW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.load_s1   (ready_s1),
		.command   (cmd.command),
		.center_x  (cmd.center_x),
		.center_y  (cmd.center_y),
		.radius    (cmd.radius),
		.color     (cmd.color),
		.fill      (cmd.fill),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1),
		.dx_s1     (dx_s1),
		.dy_s1     (dy_s1),
		.px_s1     (px_s1),
		.py_s1     (py_s1),
		.radius_s1 (radius_s1),
		.fill_s1   (fill_s1),
		.color_s1  (color_s1)
	);

	// The distance test, address arithmetic and result register.
	cpg_eval #(
		.COORD_BITS (COORD_BITS),
		.PIXEL_BITS (PIXEL_BITS),
		.PW         (PW)
	) u_eval (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_base    (frame_base_q),
		.line_pitch    (line_pitch_q),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.valid_s1      (valid_s1),
		.ctl_s1        (ctl_s1),
		.dx_s1         (dx_s1),
		.dy_s1         (dy_s1),
		.px_s1         (px_s1),
		.py_s1         (py_s1),
		.radius_s1     (radius_s1),
		.fill_s1       (fill_s1),
		.color_s1      (color_s1),
		.ready_s1      (ready_s1),
		.out_valid     (pix.valid),
		.out_ready     (pix.ready),
		.write_enable  (pix.write_enable),
		.pixel_address (pix.pixel_address),
		.pixel_color   (pix.pixel_color),
		.done_res      (pix.done_res)
	);

	// With the result register empty, every stage in front of it has room.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.valid |-> cmd.ready)
		else $error("command side stalled with an empty result register");

	// A beat that writes nothing carries a zero address and a zero color.
	a_quiet_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && !pix.write_enable |-> pix.pixel_address == '0 && pix.pixel_color == '0)
		else $error("non-writing result carries address or color");

endmodule
